// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the pattern matcher RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define DSM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define DSM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/dsm_pkg.sv -----
// ----------------------------------------------------------------------------
// Dot-star pattern matcher package
// Types, constants and register indexes shared by the matcher modules.
// ----------------------------------------------------------------------------
package dsm_pkg;

  localparam int MAX_TOKENS = 16;
  localparam int CHAR_W     = 8;
  localparam int LEN_W      = 5;
  localparam int FLAG_W     = 16;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CHAR_W-1:0] NUL_CHAR = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHARS_LOW  = 3'd0,
    CFG_CHARS_HIGH = 3'd1,
    CFG_DOT_FLAGS  = 3'd2,
    CFG_STAR_FLAGS = 3'd3,
    CFG_PAT_LENGTH = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_STEP  = 2'd0,
    MODE_START = 2'd1,
    MODE_CLOSE = 2'd2
  } mode_t;

  typedef struct packed {
    logic              action;
    logic [CHAR_W-1:0] text_char;
  } in_item_t;

  typedef struct packed {
    logic matched;
    logic hopeless;
  } out_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              dot;
    logic              star;
    logic              en;
    logic              in_range;
  } tok_t;

  typedef struct packed {
    logic              load;
    mode_t             mode;
    logic [CHAR_W-1:0] text_char;
  } ctl_t;

  typedef struct packed {
    logic adv;
    logic pass;
  } link_t;

endpackage

// ----- hw/rtl/dsm_cell.sv -----
// ----------------------------------------------------------------------------
// Pattern matcher cell
// Holds the active bit of one pattern position, advances it on a text
// character and forwards advance and star-skip signals to the next cell.
// ----------------------------------------------------------------------------
module dsm_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          first,
  input  dsm_pkg::tok_t tok,
  input  dsm_pkg::ctl_t ctl,
  input  dsm_pkg::link_t link_in,
  output dsm_pkg::link_t link_out,
  output logic          act,
  output logic          closed
);

  logic act_r;
  logic act_nxt;
  logic hit;
  logic accept;
  logic raw;

  always_comb begin
    hit    = tok.dot ? (ctl.text_char != dsm_pkg::NUL_CHAR) : (tok.ch == ctl.text_char);
    accept = act_r & hit & tok.en;
    case (ctl.mode)
      dsm_pkg::MODE_STEP:  raw = (accept & tok.star) | link_in.adv;
      dsm_pkg::MODE_START: raw = first;
      dsm_pkg::MODE_CLOSE: raw = act_r & tok.in_range;
      default:             raw = 1'b0;
    endcase
    closed        = raw | link_in.pass;
    link_out.adv  = accept & ~tok.star;
    link_out.pass = closed & tok.star & tok.en;
    act_nxt       = ctl.load ? closed : act_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= first;
    end else begin
      act_r <= act_nxt;
    end
  end

  assign act = act_r;

endmodule

// ----- hw/rtl/dot_star_pattern_matcher_top.sv -----
// ----------------------------------------------------------------------------
// Dot-star pattern matcher
// Whole-string matcher for patterns of literal, dot and starred tokens,
// built as a row of position cells.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_ready, in_data) carries one item per
// transfer: action 0 starts a new empty string, action 1 appends text_char.
// Every item gives one result on the output channel (out_valid, out_ready,
// out_data): matched when the text so far matches the whole pattern, and
// hopeless when no pattern position is left active.
// The result appears in the cycle after the input transfer, and one item is
// taken every cycle while the receiver keeps up; the whole position row is
// updated in one pass through the cells. When the receiver stalls, the
// result is held and in_ready stays low until it is taken, or is high in
// the cycle in which it is taken.
// Configuration writes on cfg_we/cfg_index/cfg_wdata take effect at once;
// in the cycle after the last write the cells re-close the active set
// under the new pattern, and in_ready is low during writes and that cycle.
// Reset clears the configuration registers to zero, makes only position zero
// active and empties the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dot_star_pattern_matcher_top #(
  parameter int MAX_TOKENS = dsm_pkg::MAX_TOKENS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  dsm_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output dsm_pkg::out_item_t               out_data,
  input  logic                             cfg_we,
  input  logic [dsm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dsm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int POS_W = MAX_TOKENS + 1;
  localparam int IDX_W = $clog2(POS_W);

  logic [dsm_pkg::CFG_DATA_W-1:0] chars_low_r;
  logic [dsm_pkg::CFG_DATA_W-1:0] chars_high_r;
  logic [dsm_pkg::FLAG_W-1:0]     dot_flags_r;
  logic [dsm_pkg::FLAG_W-1:0]     star_flags_r;
  logic [dsm_pkg::LEN_W-1:0]      pat_length_r;
  logic                           dirty_r;
  logic                           out_valid_r;
  dsm_pkg::out_item_t             out_data_r;
  dsm_pkg::out_item_t             out_data_nxt;

  logic [2*dsm_pkg::CFG_DATA_W-1:0] chars;
  logic [IDX_W-1:0]                 len_eff;
  logic                             in_accept;
  dsm_pkg::ctl_t                    ctl;
  dsm_pkg::link_t                   links [0:POS_W];
  logic [POS_W-1:0]                 act_vec;
  logic [POS_W-1:0]                 closed_vec;

  assign chars   = {chars_high_r, chars_low_r};
  assign len_eff = (pat_length_r > dsm_pkg::LEN_W'(MAX_TOKENS)) ? IDX_W'(MAX_TOKENS)
                                                                 : pat_length_r[IDX_W-1:0];

  assign in_ready  = !dirty_r && !cfg_we && (!out_valid_r || out_ready);
  assign in_accept = in_valid && in_ready;

  always_comb begin
    ctl.load      = in_accept || (dirty_r && !cfg_we);
    ctl.text_char = in_data.text_char;
    if (in_accept) begin
      ctl.mode = in_data.action ? dsm_pkg::MODE_STEP : dsm_pkg::MODE_START;
    end else begin
      ctl.mode = dsm_pkg::MODE_CLOSE;
    end
  end

  assign links[0] = '0;

  for (genvar i = 0; i < POS_W; i++) begin : g_cell
    dsm_pkg::tok_t tok;
    if (i < MAX_TOKENS) begin : g_tok
      assign tok.ch   = chars[dsm_pkg::CHAR_W*i +: dsm_pkg::CHAR_W];
      assign tok.dot  = dot_flags_r[i];
      assign tok.star = star_flags_r[i];
    end else begin : g_end
      assign tok.ch   = dsm_pkg::NUL_CHAR;
      assign tok.dot  = 1'b0;
      assign tok.star = 1'b0;
    end
    assign tok.en       = IDX_W'(i) < len_eff;
    assign tok.in_range = IDX_W'(i) <= len_eff;

    dsm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .first    (i == 0),
      .tok      (tok),
      .ctl      (ctl),
      .link_in  (links[i]),
      .link_out (links[i+1]),
      .act      (act_vec[i]),
      .closed   (closed_vec[i])
    );
  end

  always_comb begin
    out_data_nxt.matched  = closed_vec[len_eff];
    out_data_nxt.hopeless = ~|closed_vec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chars_low_r  <= '0;
      chars_high_r <= '0;
      dot_flags_r  <= '0;
      star_flags_r <= '0;
      pat_length_r <= '0;
      dirty_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      dirty_r <= cfg_we;
      if (cfg_we) begin
        case (dsm_pkg::cfg_idx_t'(cfg_index))
          dsm_pkg::CFG_CHARS_LOW:  chars_low_r  <= cfg_wdata;
          dsm_pkg::CFG_CHARS_HIGH: chars_high_r <= cfg_wdata;
          dsm_pkg::CFG_DOT_FLAGS:  dot_flags_r  <= cfg_wdata[dsm_pkg::FLAG_W-1:0];
          dsm_pkg::CFG_STAR_FLAGS: star_flags_r <= cfg_wdata[dsm_pkg::FLAG_W-1:0];
          dsm_pkg::CFG_PAT_LENGTH: pat_length_r <= cfg_wdata[dsm_pkg::LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `DSM_ASSERT(a_no_accept_when_dirty, clk, rst_n, dirty_r |-> !in_ready, "item taken during re-close")
  `DSM_ASSERT(a_result_follows, clk, rst_n, in_accept |=> out_valid_r, "no result after transfer")
  `DSM_ASSERT(a_match_not_hopeless, clk, rst_n, out_valid_r |-> !(out_data_r.matched && out_data_r.hopeless), "matched and hopeless together")
  `DSM_ASSERT_ALWAYS(a_reset_set, clk, !rst_n |=> (act_vec == POS_W'(1)), "reset set is not position zero")

endmodule

// ----- dv/dot_star_pattern_matcher_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Dot-star pattern matcher testbench
// Drives start and text items through the matcher under a series of pattern
// settings and idle mixes. It predicts the reachable pattern positions for
// every accepted item and checks each result transfer against the oldest
// prediction.
// ----------------------------------------------------------------------------
module dot_star_pattern_matcher_top_test;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int SETTLE_CYCLES   = 4;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 96;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_ready;
  dsm_pkg::in_item_t              in_data   = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  dsm_pkg::out_item_t             out_data;
  logic                           cfg_we    = 1'b0;
  logic [dsm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [dsm_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  logic [63:0] pat_chars_low  = '0;
  logic [63:0] pat_chars_high = '0;
  logic [15:0] pat_dots       = '0;
  logic [15:0] pat_stars      = '0;
  logic [4:0]  pat_len_reg    = '0;
  logic [16:0] reached_positions = 17'd1;

  dsm_pkg::in_item_t  pending_items[$];
  dsm_pkg::out_item_t expected_verdicts[$];
  dsm_pkg::out_item_t oldest_verdict;
  int                 send_idle_pct  = 0;
  int                 recv_stall_pct = 0;
  int                 mismatch_count = 0;
  int                 quiet_cycles   = 0;

  dot_star_pattern_matcher_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int tokens_in_use();
    return (pat_len_reg > dsm_pkg::MAX_TOKENS) ? dsm_pkg::MAX_TOKENS : int'(pat_len_reg);
  endfunction

  function automatic logic [7:0] token_byte(int i);
    return (i < 8) ? pat_chars_low[8*i +: 8] : pat_chars_high[8*(i-8) +: 8];
  endfunction

  function automatic bit token_takes(int i, logic [7:0] ch);
    if (pat_dots[i]) return ch != dsm_pkg::NUL_CHAR;
    return token_byte(i) == ch;
  endfunction

  function automatic logic [16:0] star_closure(logic [16:0] positions, int len);
    logic [17:0] mask;
    logic [16:0] closed;
    mask   = (18'd1 << (len + 1)) - 18'd1;
    closed = positions & mask[16:0];
    for (int i = 0; i < len; i++) begin
      if (closed[i] && pat_stars[i]) closed[i+1] = 1'b1;
    end
    return closed;
  endfunction

  // Advances the reachable position set by one item and returns the verdict.
  function automatic dsm_pkg::out_item_t apply_item(dsm_pkg::in_item_t item);
    int                 len;
    logic [16:0]        cur;
    logic [16:0]        nxt;
    dsm_pkg::out_item_t verdict;
    len = tokens_in_use();
    if (!item.action) begin
      nxt = star_closure(17'd1, len);
    end else begin
      cur = star_closure(reached_positions, len);
      nxt = '0;
      for (int i = 0; i < len; i++) begin
        if (cur[i] && token_takes(i, item.text_char)) begin
          if (pat_stars[i]) nxt[i] = 1'b1;
          else nxt[i+1] = 1'b1;
        end
      end
      nxt = star_closure(nxt, len);
    end
    reached_positions = nxt;
    verdict.matched  = nxt[len];
    verdict.hopeless = (nxt == '0);
    return verdict;
  endfunction

  function automatic void push_item(logic action_bit, logic [7:0] ch);
    dsm_pkg::in_item_t item;
    item.action    = action_bit;
    item.text_char = ch;
    pending_items.push_back(item);
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic write_register(dsm_pkg::cfg_idx_t idx, logic [63:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      dsm_pkg::CFG_CHARS_LOW:  pat_chars_low  = value;
      dsm_pkg::CFG_CHARS_HIGH: pat_chars_high = value;
      dsm_pkg::CFG_DOT_FLAGS:  pat_dots       = value[15:0];
      dsm_pkg::CFG_STAR_FLAGS: pat_stars      = value[15:0];
      dsm_pkg::CFG_PAT_LENGTH: pat_len_reg    = value[4:0];
      default: ;
    endcase
  endtask

  task automatic load_pattern(logic [63:0] lo, logic [63:0] hi, logic [63:0] dots,
                              logic [63:0] stars, logic [63:0] len_word);
    write_register(dsm_pkg::CFG_CHARS_LOW, lo);
    write_register(dsm_pkg::CFG_CHARS_HIGH, hi);
    write_register(dsm_pkg::CFG_DOT_FLAGS, dots);
    write_register(dsm_pkg::CFG_STAR_FLAGS, stars);
    write_register(dsm_pkg::CFG_PAT_LENGTH, len_word);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_random_pattern(logic [63:0] len_word);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [15:0] dots;
    logic [15:0] stars;
    for (int i = 0; i < 8; i++) begin
      lo[8*i +: 8] = ($urandom_range(3) != 0) ? 8'(8'h61 + $urandom_range(2)) : 8'($urandom);
      hi[8*i +: 8] = ($urandom_range(3) != 0) ? 8'(8'h61 + $urandom_range(2)) : 8'($urandom);
    end
    for (int i = 0; i < 16; i++) begin
      dots[i]  = ($urandom_range(3) == 0);
      stars[i] = ($urandom_range(2) == 0);
    end
    load_pattern(lo, hi, {48'($urandom), dots}, {48'($urandom), stars}, len_word);
  endtask

  // The queues are checked between edges, once all updates of an edge are settled.
  task automatic wait_for_drain();
    while (pending_items.size() != 0 || in_valid || expected_verdicts.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly a fresh string that walks the pattern, with rare slips.
  task automatic queue_pattern_text(output int added);
    int         len;
    int         reps;
    logic [7:0] ch;
    len   = tokens_in_use();
    added = 0;
    if ($urandom_range(9) != 0) begin
      push_item(1'b0, 8'($urandom));
      added++;
    end
    for (int i = 0; i < len; i++) begin
      reps = pat_stars[i] ? $urandom_range(3) : 1;
      for (int r = 0; r < reps; r++) begin
        ch = pat_dots[i] ? 8'($urandom_range(1, 255)) : token_byte(i);
        if ($urandom_range(15) == 0) ch = 8'($urandom);
        if ($urandom_range(23) != 0) begin
          push_item(1'b1, ch);
          added++;
        end
      end
    end
    if ($urandom_range(5) == 0) begin
      push_item(1'b1, 8'($urandom));
      added++;
    end
  endtask

  task automatic queue_noise(output int added);
    added = $urandom_range(1, 5);
    for (int i = 0; i < added; i++) push_item(1'($urandom), 8'($urandom));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= pending_items.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) expected_verdicts.push_back(apply_item(in_data));
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch("result transfer with no item outstanding");
        end else begin
          oldest_verdict = expected_verdicts.pop_front();
          if (out_data.matched !== oldest_verdict.matched)
            report_mismatch($sformatf("matched got %0b, expected %0b",
                                      out_data.matched, oldest_verdict.matched));
          if (out_data.hopeless !== oldest_verdict.hopeless)
            report_mismatch($sformatf("hopeless got %0b, expected %0b",
                                      out_data.hopeless, oldest_verdict.hopeless));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("dot_star_pattern_matcher_top verification failed");
        $finish;
      end
    end
  end

  initial begin
    int queued;
    int n;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Literal a, starred dot, literal star, literal null, starred 0xFF.
    load_pattern(64'h2E2E2EFF002A5A61, 64'h0, 64'h0002, 64'h0012, 64'd5);
    push_item(1'b1, 8'h61);
    push_item(1'b1, 8'h71);
    push_item(1'b1, 8'h2A);
    push_item(1'b1, 8'h00);
    push_item(1'b1, 8'hFF);
    push_item(1'b1, 8'hFF);
    push_item(1'b1, 8'h01);
    push_item(1'b0, 8'hFF);
    push_item(1'b1, 8'h00);
    push_item(1'b0, 8'h00);
    push_item(1'b1, 8'h61);
    push_item(1'b1, 8'h5A);
    push_item(1'b1, 8'h5A);
    push_item(1'b1, 8'h2A);
    push_item(1'b1, 8'h00);
    wait_for_drain();

    // Shorten the pattern in the middle of a string.
    write_register(dsm_pkg::CFG_PAT_LENGTH, 64'd3);
    @(posedge clk);
    cfg_we <= 1'b0;
    push_item(1'b1, 8'h2A);
    push_item(1'b1, 8'h2A);
    wait_for_drain();

    // A literal period followed by a dot.
    load_pattern(64'h00002E2E, 64'h0, 64'h0002, 64'h0, 64'd2);
    push_item(1'b0, 8'h00);
    push_item(1'b1, 8'h2E);
    push_item(1'b1, 8'h78);
    push_item(1'b0, 8'h00);
    push_item(1'b1, 8'h78);
    wait_for_drain();

    // Oversized length with every token a starred dot.
    load_pattern('1, '1, 64'hFFFF, 64'hFFFF, 64'd20);
    push_item(1'b0, 8'h55);
    push_item(1'b1, 8'h41);
    push_item(1'b1, 8'h00);
    push_item(1'b1, 8'h41);
    push_item(1'b0, 8'hAA);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_for_drain();
      case (phase)
        0: load_random_pattern(64'd16);
        1: load_pattern('1, '1, 64'hFFFF, 64'hFFFF, 64'd0);
        2: load_random_pattern({$urandom, 27'($urandom), 5'd31});
        3: load_random_pattern(64'($urandom_range(1, 4)));
        4: load_pattern({$urandom, $urandom}, {$urandom, $urandom}, 64'hFFFF, 64'hFFFF, 64'd16);
        5: load_pattern('0, '0, 64'h0, 64'h0, 64'd16);
        6: load_pattern('1, '1, 64'h0, 64'h5555, 64'd8);
        default: load_random_pattern(64'($urandom_range(1, 16)));
      endcase
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      queued = 0;
      while (queued < ITEMS_PER_PHASE) begin
        if ($urandom_range(4) != 0) queue_pattern_text(n);
        else queue_noise(n);
        queued += n;
      end
    end

    wait_for_drain();
    if (mismatch_count == 0) begin
      $display("dot_star_pattern_matcher_top verification clean");
    end else begin
      $display("dot_star_pattern_matcher_top verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/dsm_pkg.sv
hw/rtl/dsm_cell.sv
hw/rtl/dot_star_pattern_matcher_top.sv
dv/dot_star_pattern_matcher_top_test.sv
